/* hdl/cle_pkg.sv */
package cle_pkg;

    // Default depth of the line store
    localparam int LE_BUF_DEPTH = 128;

    // Character codes
    localparam logic [7:0] CH_EOF  = 8'h04;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_DUMP = 8'h10;
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Read status codes
    localparam logic [1:0] RD_WAIT = 2'd0;
    localparam logic [1:0] RD_BYTE = 2'd1;
    localparam logic [1:0] RD_EOF  = 2'd2;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // One result item
    typedef struct packed {
        logic       read_ends_line;
        logic [7:0] read_byte;
        logic [1:0] read_status;
        logic       char_dropped;
        logic       line_committed;
        logic       dump_request;
        logic [7:0] erase_count;
        logic [7:0] echo_char;
        logic       echo_valid;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic take_item;
        logic exec;
        logic kill_rd;
        logic kill_step;
        logic read_rd;
        logic read_done;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_read;
        logic is_kill;
        logic edit_eq_commit;
        logic read_eq_commit;
        logic data_is_lf;
    } t_sts;

endpackage

/* hdl/cle_ram.sv */
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cle_pkg::LE_BUF_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/cle_dp.sv */
module cle_dp #(
    parameter int BUF_DEPTH = cle_pkg::LE_BUF_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cle_pkg::t_cmd    i_cmd,
    output cle_pkg::t_sts    o_sts,
    input  logic             i_func,
    input  logic [7:0]       i_rx_char,
    input  logic             i_first,
    output cle_pkg::t_result o_result
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(BUF_DEPTH - 1);

    // Index is {wrap, slot}; slot counts 0 .. BUF_DEPTH-1
    function automatic logic [AW:0] idx_inc(input logic [AW:0] x);
        logic [AW:0] y;
        if (x[AW-1:0] == LAST) begin
            y = {~x[AW], {AW{1'b0}}};
        end else begin
            y = {x[AW], x[AW-1:0] + AW'(1)};
        end
        return y;
    endfunction

    function automatic logic [AW:0] idx_dec(input logic [AW:0] x);
        logic [AW:0] y;
        if (x[AW-1:0] == {AW{1'b0}}) begin
            y = {~x[AW], LAST};
        end else begin
            y = {x[AW], x[AW-1:0] - AW'(1)};
        end
        return y;
    endfunction

    logic             r_func, n_func;
    logic [7:0]       r_char, n_char;
    logic             r_first, n_first;
    logic [AW:0]      r_edit, n_edit;
    logic [AW:0]      r_commit, n_commit;
    logic [AW:0]      r_read, n_read;
    cle_pkg::t_result r_res, n_res;
    cle_pkg::t_result r_out, n_out;

    logic [7:0]  mapped;
    logic [AW:0] edit_inc;
    logic [AW:0] edit_dec;
    logic        full;
    logic        full_after;
    logic        is_erase1;
    logic        ord_ok;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]  ram_rdata;

    // Decode the held item
    assign mapped     = (r_char == cle_pkg::CH_CR) ? cle_pkg::CH_LF : r_char;
    assign edit_inc   = idx_inc(r_edit);
    assign edit_dec   = idx_dec(r_edit);
    assign full       = (r_edit[AW] != r_read[AW]) && (r_edit[AW-1:0] == r_read[AW-1:0]);
    assign full_after = (edit_inc[AW] != r_read[AW])
                        && (edit_inc[AW-1:0] == r_read[AW-1:0]);
    assign is_erase1  = (r_char == cle_pkg::CH_BS) || (r_char == cle_pkg::CH_DEL);
    assign ord_ok     = !r_func && (r_char != cle_pkg::CH_DUMP)
                        && (r_char != cle_pkg::CH_KILL) && !is_erase1
                        && (r_char != cle_pkg::CH_NUL) && !full;

    // Line store access
    assign ram_we    = i_cmd.exec && ord_ok;
    assign ram_re    = i_cmd.kill_rd || i_cmd.read_rd;
    assign ram_raddr = i_cmd.kill_rd ? edit_dec[AW-1:0] : r_read[AW-1:0];

    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_edit[AW-1:0]),
        .i_wdata (mapped),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next-state logic for indices and result
    always_comb begin
        n_func   = r_func;
        n_char   = r_char;
        n_first  = r_first;
        n_edit   = r_edit;
        n_commit = r_commit;
        n_read   = r_read;
        n_res    = r_res;
        n_out    = r_out;

        if (i_cmd.take_item) begin
            n_func  = i_func;
            n_char  = i_rx_char;
            n_first = i_first;
            n_res   = '0;
        end

        if (i_cmd.exec && !r_func) begin
            if (r_char == cle_pkg::CH_DUMP) begin
                n_res.dump_request = 1'b1;
            end else if (r_char == cle_pkg::CH_KILL) begin
                // walk is driven by kill_step
            end else if (is_erase1) begin
                if (r_edit != r_commit) begin
                    n_edit            = edit_dec;
                    n_res.erase_count = 8'd1;
                end
            end else if (ord_ok) begin
                n_res.echo_valid = 1'b1;
                n_res.echo_char  = mapped;
                n_edit           = edit_inc;
                if ((mapped == cle_pkg::CH_LF) || (mapped == cle_pkg::CH_EOF)
                    || full_after) begin
                    n_commit             = edit_inc;
                    n_res.line_committed = 1'b1;
                end
            end else begin
                n_res.char_dropped = 1'b1;
            end
        end

        // Erase one character of a line kill, saturating the count
        if (i_cmd.kill_step) begin
            n_edit = edit_dec;
            if (r_res.erase_count != 8'hFF) begin
                n_res.erase_count = r_res.erase_count + 8'd1;
            end
        end

        // Finish a read with the fetched byte
        if (i_cmd.read_done) begin
            if (ram_rdata == cle_pkg::CH_EOF) begin
                if (r_first) begin
                    n_read = idx_inc(r_read);
                end
                n_res.read_status = cle_pkg::RD_EOF;
            end else begin
                n_read               = idx_inc(r_read);
                n_res.read_status    = cle_pkg::RD_BYTE;
                n_res.read_byte      = ram_rdata;
                n_res.read_ends_line = (ram_rdata == cle_pkg::CH_LF);
            end
        end

        if (i_cmd.load_out) begin
            n_out = r_res;
        end
    end

    // Indices reset; payload holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit   <= '0;
            r_commit <= '0;
            r_read   <= '0;
        end else begin
            r_edit   <= n_edit;
            r_commit <= n_commit;
            r_read   <= n_read;
        end
        r_func  <= n_func;
        r_char  <= n_char;
        r_first <= n_first;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_sts.is_read        = r_func;
    assign o_sts.is_kill        = (r_char == cle_pkg::CH_KILL);
    assign o_sts.edit_eq_commit = (r_edit == r_commit);
    assign o_sts.read_eq_commit = (r_read == r_commit);
    assign o_sts.data_is_lf     = (ram_rdata == cle_pkg::CH_LF);
    assign o_result             = r_out;

endmodule

/* hdl/cle_ctrl.sv */
module cle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cle_pkg::t_sts i_sts,
    output cle_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_KRD   = 3'd2;
    localparam logic [2:0] S_KWAIT = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // Sequence one item through the datapath
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_read) begin
                    if (!i_sts.read_eq_commit) begin
                        o_cmd.read_rd = 1'b1;
                        n_state       = S_RWAIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.is_kill) begin
                    n_state = S_KRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_KRD: begin
                if (i_sts.edit_eq_commit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.kill_rd = 1'b1;
                    n_state       = S_KWAIT;
                end
            end
            S_KWAIT: begin
                if (i_sts.data_is_lf) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.kill_step = 1'b1;
                    n_state         = S_KRD;
                end
            end
            S_RWAIT: begin
                o_cmd.read_done = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/console_line_editor.sv */
// Canonical console input editor over a circular line store of BUF_DEPTH
// bytes. Each input item is either a received character (tuser = 0) or a
// reader request for one byte (tuser = 1), and gives exactly one result item.
// A read that fetches a byte waits on the registered read port of the store.
// A line kill (Ctrl-U) walks back one entry at a time through that single
// registered read port, stopping at the commit point or at a newline. A new
// item is accepted as soon as the previous one is finished, while its result
// still waits in the output register; a finished item whose predecessor's
// result is still untaken waits for that result to leave. The store needs no
// clearing after reset.
module console_line_editor #(
    parameter int BUF_DEPTH = cle_pkg::LE_BUF_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] rx_char, [8] first_in_read, [15:9] zero
    input  logic [cle_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] func
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [16:9] erase_count, [17] dump_request,
    // [18] line_committed, [19] char_dropped, [21:20] read_status,
    // [29:22] read_byte, [30] read_ends_line, [31] zero
    output logic [cle_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    cle_pkg::t_cmd    cmd;
    cle_pkg::t_sts    sts;
    cle_pkg::t_result result;

    cle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cle_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_func    (i_s_axis_tuser),
        .i_rx_char (i_s_axis_tdata[7:0]),
        .i_first   (i_s_axis_tdata[8]),
        .o_result  (result)
    );

    // Pack the result item
    assign o_m_axis_tdata = {1'b0, result};

    // One item in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("item accepted while another is in flight");

    // A read result never carries character-side fields
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (result.read_status != cle_pkg::RD_WAIT))
        |-> (!result.echo_valid && (result.erase_count == 8'd0) && !result.char_dropped))
        else $error("read result mixed with character result");

    // An echoed character is nonzero, never CR, and was not dropped
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && result.echo_valid)
        |-> ((result.echo_char != cle_pkg::CH_NUL) && !result.char_dropped
             && (result.echo_char != cle_pkg::CH_CR)))
        else $error("bad echo");

    // A commit only comes with an echoed character
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && result.line_committed) |-> result.echo_valid)
        else $error("commit without stored character");

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = cle_pkg::LE_BUF_DEPTH;
    localparam int IDX_MOD    = 2 * DEPTH;
    localparam int QUIET_MAX  = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_ITEMS = 50;

    typedef enum logic {
        FN_CHAR = 1'b0,
        FN_READ = 1'b1
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] ch;
        logic       first;
    } t_key_item;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cle_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cle_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Pending keyboard/read items and results still owed by the editor
    t_key_item        pending_items[$];
    cle_pkg::t_result expected_results[$];

    // Shadow of the line store and its three indices
    logic [7:0] store_bytes [DEPTH];
    int         rd_idx;
    int         cm_idx;
    int         ed_idx;

    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_active = 1'b0;
    logic in_taken = 1'b0;
    int   err_count = 0;
    int   quiet_cycles = 0;
    int   pushed = 0;

    console_line_editor i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Step a circular index forward or back
    function automatic int idx_step(int a, int d);
        return (a + IDX_MOD + d) % IDX_MOD;
    endfunction

    // Apply one item to the shadow state and return the result it must produce
    function automatic cle_pkg::t_result line_discipline_step(t_key_item it);
        cle_pkg::t_result res;
        int               n;
        logic [7:0]       c;
        logic [7:0]       b;
        res = '0;
        c = it.ch;
        if (it.func == FN_CHAR) begin
            if (c == cle_pkg::CH_DUMP) begin
                res.dump_request = 1'b1;
            end else if (c == cle_pkg::CH_KILL) begin
                n = 0;
                while (ed_idx != cm_idx &&
                       store_bytes[idx_step(ed_idx, -1) % DEPTH] != cle_pkg::CH_LF) begin
                    ed_idx = idx_step(ed_idx, -1);
                    n++;
                end
                res.erase_count = (n > 255) ? 8'd255 : n[7:0];
            end else if (c == cle_pkg::CH_BS || c == cle_pkg::CH_DEL) begin
                if (ed_idx != cm_idx) begin
                    ed_idx = idx_step(ed_idx, -1);
                    res.erase_count = 8'd1;
                end
            end else if (c != cle_pkg::CH_NUL && idx_step(ed_idx, -rd_idx) < DEPTH) begin
                if (c == cle_pkg::CH_CR)
                    c = cle_pkg::CH_LF;
                res.echo_valid = 1'b1;
                res.echo_char = c;
                store_bytes[ed_idx % DEPTH] = c;
                ed_idx = idx_step(ed_idx, 1);
                if (c == cle_pkg::CH_LF || c == cle_pkg::CH_EOF ||
                    idx_step(ed_idx, -rd_idx) == DEPTH) begin
                    cm_idx = ed_idx;
                    res.line_committed = 1'b1;
                end
            end else begin
                res.char_dropped = 1'b1;
            end
        end else if (rd_idx != cm_idx) begin
            b = store_bytes[rd_idx % DEPTH];
            if (b == cle_pkg::CH_EOF) begin
                if (it.first)
                    rd_idx = idx_step(rd_idx, 1);
                res.read_status = cle_pkg::RD_EOF;
            end else begin
                rd_idx = idx_step(rd_idx, 1);
                res.read_status = cle_pkg::RD_BYTE;
                res.read_byte = b;
                res.read_ends_line = (b == cle_pkg::CH_LF);
            end
        end else begin
            res.read_status = cle_pkg::RD_WAIT;
        end
        return res;
    endfunction

    // Count a failure, show only the first few
    task automatic report_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want !== got)
            report_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    task automatic push_char(logic [7:0] c);
        pending_items.push_back('{func: FN_CHAR, ch: c, first: 1'($urandom_range(1))});
        pushed++;
    endtask

    task automatic push_read(logic f);
        pending_items.push_back('{func: FN_READ, ch: 8'($urandom_range(255)), first: f});
        pushed++;
    endtask

    // Ordinary character, none of the editing or line codes
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == cle_pkg::CH_EOF || c == cle_pkg::CH_BS || c == cle_pkg::CH_LF ||
               c == cle_pkg::CH_CR || c == cle_pkg::CH_DUMP || c == cle_pkg::CH_KILL ||
               c == cle_pkg::CH_DEL);
        return c;
    endfunction

    // Typed character with a share of editing keys mixed in
    function automatic logic [7:0] typed_char();
        int r;
        r = $urandom_range(99);
        if (r < 4)       return cle_pkg::CH_BS;
        else if (r < 8)  return cle_pkg::CH_DEL;
        else if (r < 11) return cle_pkg::CH_KILL;
        else if (r < 14) return cle_pkg::CH_DUMP;
        else if (r < 16) return cle_pkg::CH_NUL;
        else if (r < 18) return cle_pkg::CH_CR;
        else             return 8'($urandom_range(255));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Sender: offer the next pending item, or idle
    always @(negedge clk) begin
        t_key_item nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt.func;
                s_tdata <= {7'b0, nxt.first, nxt.ch};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off
    always @(negedge clk) begin
        m_tready <= rst_n && !hold_active && ($urandom_range(99) >= stall_pct);
    end

    // Long receiver hold-off, timed on its own
    initial begin
        wait (hold_go);
        @(negedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_active <= 1'b0;
    end

    // Monitor: check results, predict from accepted items
    always @(posedge clk) begin
        cle_pkg::t_result got;
        cle_pkg::t_result want;
        t_key_item        it;
        in_taken <= s_tvalid && s_tready && rst_n;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = cle_pkg::t_result'(m_tdata[30:0]);
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result with none expected: %h", m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("echo_valid", want.echo_valid, got.echo_valid);
                    check_field("echo_char", want.echo_char, got.echo_char);
                    check_field("erase_count", want.erase_count, got.erase_count);
                    check_field("dump_request", want.dump_request, got.dump_request);
                    check_field("line_committed", want.line_committed, got.line_committed);
                    check_field("char_dropped", want.char_dropped, got.char_dropped);
                    check_field("read_status", want.read_status, got.read_status);
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("read_ends_line", want.read_ends_line, got.read_ends_line);
                end
            end
            if (s_tvalid && s_tready) begin
                it = '{func: t_func'(s_tuser), ch: s_tdata[7:0], first: s_tdata[8]};
                expected_results.push_back(line_discipline_step(it));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int idle_tab [4];
        int stall_tab [4];
        int r;
        int len;
        idle_tab = '{0, 48, 0, 37};
        stall_tab = '{0, 0, 48, 37};
        rd_idx = 0;
        cm_idx = 0;
        ed_idx = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-store edits, drops, kill, CR mapping, EOF handling
        push_read(1'b1);
        push_char(cle_pkg::CH_DUMP);
        push_char(cle_pkg::CH_KILL);
        push_char(cle_pkg::CH_BS);
        push_char(cle_pkg::CH_DEL);
        push_char(cle_pkg::CH_NUL);
        push_char(8'hFF);
        push_char(8'h80);
        push_char(cle_pkg::CH_BS);
        push_char(cle_pkg::CH_DEL);
        push_char(8'h61);
        push_char(8'h01);
        push_char(8'h7E);
        push_char(cle_pkg::CH_KILL);
        push_char(8'h7A);
        push_char(cle_pkg::CH_CR);
        push_char(8'h6B);
        push_char(cle_pkg::CH_EOF);
        push_read(1'b1);
        push_read(1'b0);
        push_read(1'b1);
        push_read(1'b0);
        push_read(1'b1);
        push_read(1'b1);
        push_char(cle_pkg::CH_LF);
        push_read(1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p == 0) begin
                // Fill the store to its limit while the receiver holds off
                hold_go = 1'b1;
                repeat (DEPTH) push_char(plain_char());
                repeat (3) push_char(plain_char());
                push_char(cle_pkg::CH_KILL);
                push_char(cle_pkg::CH_BS);
                repeat (DEPTH + 2) push_read(1'($urandom_range(1)));
            end
            pushed = 0;
            while (pushed < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    // Edited line, terminated, then read back in part or whole
                    len = $urandom_range(12);
                    repeat (len) push_char(typed_char());
                    case ($urandom_range(2))
                        0: push_char(cle_pkg::CH_CR);
                        1: push_char(cle_pkg::CH_LF);
                        default: push_char(cle_pkg::CH_EOF);
                    endcase
                    repeat ($urandom_range(len + 4)) push_read($urandom_range(9) < 7);
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 8)) push_read(1'($urandom_range(1)));
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        pending_items.push_back('{func: t_func'($urandom_range(1)),
                                                  ch: 8'($urandom_range(255)),
                                                  first: 1'($urandom_range(1))});
                        pushed++;
                    end
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
